### rtl/rkd_pkg.sv
// ----------------------------------------------------------------------------
// RSA key derivation package
// Shared widths, status codes, payload structs and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package rkd_pkg;

    localparam int PRIME_BITS = 20;
    localparam int WORD_BITS  = 2 * PRIME_BITS;
    localparam int ACC_BITS   = WORD_BITS + 1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_FACTOR = 2'd1;
    localparam logic [1:0] ST_NO_EXP     = 2'd2;

    typedef struct packed {
        logic [PRIME_BITS-1:0] prime_p;
        logic [PRIME_BITS-1:0] prime_q;
    } rkd_in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] carmichael_lambda;
        logic [WORD_BITS-1:0] public_exp;
        logic [WORD_BITS-1:0] private_exp;
        logic [1:0]           status;
    } rkd_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_ST1,
        OP_GCD1_INIT,
        OP_STEP,
        OP_SET_LAM,
        OP_SET_ST2,
        OP_C_INIT,
        OP_C_INC,
        OP_GCD2_INIT,
        OP_INV_INIT,
        OP_INV_RED,
        OP_INV_FIX,
        OP_NO_INV,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_start;
        logic   div_lambda;
    } dp_cmd_t;

    typedef struct packed {
        logic factor_low;
        logic b_zero;
        logic b_one;
        logic a_one;
        logic lam_small;
        logic c_ge_lam;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/rkd_divider.sv
// ----------------------------------------------------------------------------
// RKD restoring divider
// One quotient bit per cycle; also forms quotient * multiplicand (Horner).
// ----------------------------------------------------------------------------
`default_nettype none

module rkd_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [rkd_pkg::WORD_BITS-1:0] dividend,
    input  wire logic [rkd_pkg::WORD_BITS-1:0] divisor,
    input  wire logic [rkd_pkg::ACC_BITS-1:0]  multiplicand,
    output logic                               done,
    output logic [rkd_pkg::WORD_BITS-1:0]      remainder,
    output logic [rkd_pkg::ACC_BITS-1:0]       product
);
    import rkd_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] dvd_reg;
    logic [WORD_BITS-1:0] dsr_reg;
    logic [ACC_BITS-1:0]  mul_reg;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    logic [WORD_BITS:0]   trial;
    logic                 ge;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[WORD_BITS-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? WORD_BITS'(trial - {1'b0, dsr_reg}) : trial[WORD_BITS-1:0];
        acc_next = {acc_reg[ACC_BITS-2:0], 1'b0} + (ge ? mul_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            mul_reg <= multiplicand;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WORD_BITS-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished division");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && dsr_reg != '0 |-> rem_reg < dsr_reg)
        else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

### rtl/rkd_datapath.sv
// ----------------------------------------------------------------------------
// RKD datapath
// Operand registers, Euclid/Bezout state, result register and shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rkd_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rkd_pkg::rkd_in_t  item,
    input  wire rkd_pkg::dp_cmd_t  cmd,
    output rkd_pkg::dp_stat_t      stat,
    output rkd_pkg::rkd_out_t      key
);
    import rkd_pkg::*;

    localparam int PAD = WORD_BITS - PRIME_BITS;

    logic [PRIME_BITS-1:0] p_reg, q_reg;
    logic [PRIME_BITS-1:0] pm, qm;
    logic [WORD_BITS-1:0]  n_reg, lam_reg, c_reg, e_reg, d_reg;
    logic [WORD_BITS-1:0]  a_reg, b_reg;
    logic [ACC_BITS-1:0]   t0_reg, t1_reg;
    logic                  neg_reg;
    logic [1:0]            st_reg;
    rkd_out_t              res_reg;
    logic [WORD_BITS-1:0]  pq;

    logic [WORD_BITS-1:0]  div_dividend, div_divisor, div_rem;
    logic [ACC_BITS-1:0]   div_mul, div_prod;
    logic                  div_done;

    assign pm = p_reg - 1'b1;
    assign qm = q_reg - 1'b1;
    assign pq = WORD_BITS'(p_reg) * WORD_BITS'(q_reg);

    // lambda pass: (p-1)/g with q-1 as multiplicand gives lambda directly
    assign div_dividend = cmd.div_lambda ? {{PAD{1'b0}}, pm} : a_reg;
    assign div_divisor  = cmd.div_lambda ? a_reg : b_reg;
    assign div_mul      = cmd.div_lambda ? {{(ACC_BITS-PRIME_BITS){1'b0}}, qm} : t1_reg;

    rkd_divider u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.div_start),
        .dividend     (div_dividend),
        .divisor      (div_divisor),
        .multiplicand (div_mul),
        .done         (div_done),
        .remainder    (div_rem),
        .product      (div_prod)
    );

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                p_reg   <= item.prime_p;
                q_reg   <= item.prime_q;
                n_reg   <= '0;
                lam_reg <= '0;
                e_reg   <= '0;
                d_reg   <= '0;
                st_reg  <= ST_OK;
            end
            OP_SET_ST1:   st_reg <= ST_BAD_FACTOR;
            OP_GCD1_INIT:
            begin
                a_reg <= {{PAD{1'b0}}, pm};
                b_reg <= {{PAD{1'b0}}, qm};
                n_reg <= pq;
            end
            OP_STEP:
            begin
                a_reg   <= b_reg;
                b_reg   <= div_rem;
                t0_reg  <= t1_reg;
                t1_reg  <= t0_reg + div_prod;
                neg_reg <= ~neg_reg;
            end
            OP_SET_LAM:   lam_reg <= div_prod[WORD_BITS-1:0];
            OP_SET_ST2:   st_reg <= ST_NO_EXP;
            OP_C_INIT:    c_reg <= WORD_BITS'(3);
            OP_C_INC:     c_reg <= c_reg + 1'b1;
            OP_GCD2_INIT:
            begin
                a_reg <= c_reg;
                b_reg <= lam_reg;
            end
            OP_INV_INIT:
            begin
                e_reg   <= c_reg;
                a_reg   <= lam_reg;
                b_reg   <= c_reg;
                t0_reg  <= '0;
                t1_reg  <= ACC_BITS'(1);
                neg_reg <= 1'b0;
            end
            OP_INV_RED:
            begin
                if (t1_reg >= {1'b0, lam_reg})
                    t1_reg <= t1_reg - {1'b0, lam_reg};
            end
            OP_INV_FIX:
            begin
                if (neg_reg && t1_reg != '0)
                    d_reg <= lam_reg - t1_reg[WORD_BITS-1:0];
                else
                    d_reg <= t1_reg[WORD_BITS-1:0];
            end
            OP_NO_INV:    d_reg <= '0;
            OP_RESULT:
            begin
                res_reg.modulus           <= n_reg;
                res_reg.carmichael_lambda <= lam_reg;
                res_reg.public_exp        <= e_reg;
                res_reg.private_exp       <= d_reg;
                res_reg.status            <= st_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.factor_low = (p_reg < PRIME_BITS'(2)) || (q_reg < PRIME_BITS'(2));
        stat.b_zero     = (b_reg == '0);
        stat.b_one      = (b_reg == WORD_BITS'(1));
        stat.a_one      = (a_reg == WORD_BITS'(1));
        stat.lam_small  = (lam_reg <= WORD_BITS'(3));
        stat.c_ge_lam   = (c_reg >= lam_reg);
        stat.div_done   = div_done;
    end

    assign key = res_reg;

endmodule

`default_nettype wire

### rtl/rkd_control.sv
// ----------------------------------------------------------------------------
// RKD controller
// Sequences gcd, lambda, exponent search and inverse; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rkd_control (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    output logic                   key_valid,
    input  wire logic              key_stall,
    input  wire rkd_pkg::dp_stat_t stat,
    output rkd_pkg::dp_cmd_t       cmd
);
    import rkd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_G1_TEST,
        S_G1_WAIT,
        S_LAM_WAIT,
        S_LAM_CHK,
        S_SRCH,
        S_G2_TEST,
        S_G2_WAIT,
        S_INV_TEST,
        S_INV_WAIT,
        S_INV_RED,
        S_INV_FIX,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   key_valid_reg, key_valid_next;
    logic   slot_free;

    assign slot_free = !key_valid_reg || !key_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.div_start  = 1'b0;
        cmd.div_lambda = 1'b0;
        key_valid_next = key_valid_reg && key_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.factor_low)
                begin
                    cmd.op     = OP_SET_ST1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_GCD1_INIT;
                    state_next = S_G1_TEST;
                end
            end
            S_G1_TEST:
            begin
                cmd.div_start = 1'b1;
                if (stat.b_zero)
                begin
                    cmd.div_lambda = 1'b1;
                    state_next     = S_LAM_WAIT;
                end
                else
                begin
                    state_next = S_G1_WAIT;
                end
            end
            S_G1_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_G1_TEST;
                end
            end
            S_LAM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_SET_LAM;
                    state_next = S_LAM_CHK;
                end
            end
            S_LAM_CHK:
            begin
                if (stat.lam_small)
                begin
                    cmd.op     = OP_SET_ST2;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_C_INIT;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (stat.c_ge_lam)
                begin
                    cmd.op     = OP_SET_ST2;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_GCD2_INIT;
                    state_next = S_G2_TEST;
                end
            end
            S_G2_TEST:
            begin
                if (stat.b_zero)
                begin
                    if (stat.a_one)
                    begin
                        cmd.op     = OP_INV_INIT;
                        state_next = S_INV_TEST;
                    end
                    else
                    begin
                        cmd.op     = OP_C_INC;
                        state_next = S_SRCH;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_G2_WAIT;
                end
            end
            S_G2_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_G2_TEST;
                end
            end
            S_INV_TEST:
            begin
                if (stat.b_one)
                begin
                    state_next = S_INV_RED;
                end
                else if (stat.b_zero)
                begin
                    cmd.op     = OP_NO_INV;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_INV_WAIT;
                end
            end
            S_INV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_INV_TEST;
                end
            end
            S_INV_RED:
            begin
                cmd.op     = OP_INV_RED;
                state_next = S_INV_FIX;
            end
            S_INV_FIX:
            begin
                cmd.op     = OP_INV_FIX;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_RESULT;
                    key_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_valid_reg <= key_valid_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);
    assign key_valid  = key_valid_reg;

`ifndef NO_ASSERTIONS
    a_wait_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_G1_WAIT || state_reg == S_G2_WAIT
                          || state_reg == S_INV_WAIT || state_reg == S_LAM_WAIT)
        else $error("division started outside a wait sequence");
    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RESULT |-> slot_free)
        else $error("result overwrote an untaken transaction");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |=> state_reg == S_CHECK)
        else $error("load did not begin a derivation");
`endif

endmodule

`default_nettype wire

### rtl/rsa_key_derivation.sv
// ----------------------------------------------------------------------------
// RSA key derivation
// From two factors p and q: modulus, Carmichael lambda, public and private
// exponents and a status code.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  item     | item_valid / item_stall | prime_p, prime_q
//  key      | key_valid  / key_stall  | modulus, lambda, exponents, status
//
// One transaction at a time. Every division runs through one shared
// restoring divider: the Euclid steps of gcd(p-1,q-1), the lambda pass,
// the gcd divisions of the search for e and the steps of the inverse.
// A factor below two skips the divider and goes straight to the result.
// Reset clears the controller and the output valid; no clearing pass.
// A finished key waits in the output register; the next item is taken
// while it is stalled, and is held in its last state until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_key_derivation (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire rkd_pkg::rkd_in_t  item,
    output logic                   key_valid,
    input  wire logic              key_stall,
    output rkd_pkg::rkd_out_t      key
);
    import rkd_pkg::*;

    // controller <-> datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    rkd_control u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // operands, Bezout state and the shared divider
    rkd_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .stat  (stat),
        .key   (key)
    );

endmodule

`default_nettype wire
